### src/hdc_pkg.sv
// Shared types and constants for the differential drive heading controller.
// Used by hdc_volts and differential_drive_heading_control; no dependencies.
package hdc_pkg;

  // Drive mode codes, as loaded by a command request and reported on the output.
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_USER     = 2'd0;
  localparam mode_t MODE_HEADING  = 2'd1;
  localparam mode_t MODE_DISTANCE = 2'd2;
  localparam mode_t MODE_SPARE    = 2'd3;

  // Request opcodes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Configuration register indexes.
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_STICK_DEADZONE  = 3'd0;
  localparam cfg_idx_t REG_MAX_TURN        = 3'd1;
  localparam cfg_idx_t REG_MAX_SLOW_TURN   = 3'd2;
  localparam cfg_idx_t REG_MIN_TURN        = 3'd3;
  localparam cfg_idx_t REG_MIN_DRIVE       = 3'd4;
  localparam cfg_idx_t REG_PULSE_ON        = 3'd5;
  localparam cfg_idx_t REG_PULSE_OFF       = 3'd6;

  // Configuration reset values.
  localparam logic [6:0] RST_STICK_DEADZONE = 7'd10;
  localparam logic [6:0] RST_MAX_TURN       = 7'd80;
  localparam logic [6:0] RST_MAX_SLOW_TURN  = 7'd40;
  localparam logic [6:0] RST_MIN_TURN       = 7'd30;
  localparam logic [6:0] RST_MIN_DRIVE      = 7'd25;
  localparam logic [5:0] RST_PULSE_ON       = 6'd1;
  localparam logic [5:0] RST_PULSE_OFF      = 6'd16;

  // Heading arithmetic, in 1/16 degree.
  localparam logic signed [15:0] HEADING_FULL = 16'sd5760;
  localparam logic signed [15:0] HEADING_HALF = 16'sd2880;
  localparam logic signed [13:0] FACE_NONE    = -14'sd1;

  // Distance scaling saturates at this many encoder degrees.
  localparam logic [4:0] DIST_FULL = 5'd16;

  // Stick square: floor(x / 127) is estimated as (x * STICK_RECIP) >> 22,
  // which is low by at most one and then corrected.
  localparam logic [6:0]  STICK_DIV   = 7'd127;
  localparam logic [15:0] STICK_RECIP = 16'((64'd1 << 22) / 64'd127);

  // Voltage: 12000 * s / (127 * 256) equals 375 * s / 1016 exactly.
  localparam logic [8:0]  VOLT_MUL   = 9'd375;
  localparam logic [9:0]  VOLT_DIV   = 10'd1016;
  localparam logic [22:0] VOLT_RECIP = 23'((64'd375 << 24) / 64'd1016);
  localparam logic [13:0] VOLT_MAX   = 14'd12000;

  // Load enables for the stages of the voltage converter.
  typedef struct packed {
    logic abs_load;
    logic est_load;
    logic out_load;
  } volt_adv_t;

endpackage

### src/hdc_volts.sv
// Speed sum to saturated motor voltage, three register stages.
// Depends on hdc_pkg for the scaling constants and the stage enable struct.
module hdc_volts (
  input  logic                   clk,
  input  hdc_pkg::volt_adv_t     adv,
  input  logic signed [17:0]     sum,
  output logic signed [14:0]     volt
);
  import hdc_pkg::*;

  logic [16:0]        mag_r;
  logic               neg_r;
  logic [16:0]        mag2_r;
  logic               neg2_r;
  logic [14:0]        est_r;
  logic signed [14:0] volt_r;

  logic [16:0] mag_nxt;
  logic [39:0] prod;
  logic [14:0] est_nxt;
  logic [25:0] exact;
  logic [25:0] back;
  logic [25:0] rem;
  logic [15:0] quot;
  logic [13:0] sat;
  logic signed [14:0] volt_nxt;

  // Magnitude and sign of the speed sum.
  assign mag_nxt = sum[17] ? 17'(-sum) : 17'(sum);

  // Reciprocal estimate of floor(mag * 375 / 1016), low by at most one.
  assign prod    = 40'(mag_r) * 40'(VOLT_RECIP);
  assign est_nxt = prod[38:24];

  // Exact remainder check, then saturation and sign.
  always_comb begin
    exact = 26'(mag2_r) * 26'(VOLT_MUL);
    back  = 26'(est_r) * 26'(VOLT_DIV);
    rem   = exact - back;
    quot  = (rem >= 26'(VOLT_DIV)) ? (16'(est_r) + 16'd1) : 16'(est_r);
    sat   = (quot > 16'(VOLT_MAX)) ? VOLT_MAX : quot[13:0];
    volt_nxt = neg2_r ? 15'(-$signed({1'b0, sat})) : $signed({1'b0, sat});
  end

  always_ff @(posedge clk) begin
    if (adv.abs_load) begin
      mag_r <= mag_nxt;
      neg_r <= sum[17];
    end
    if (adv.est_load) begin
      est_r  <= est_nxt;
      mag2_r <= mag_r;
      neg2_r <= neg_r;
    end
    if (adv.out_load) begin
      volt_r <= volt_nxt;
    end
  end

  assign volt = volt_r;

endmodule

### src/differential_drive_heading_control.sv
// Differential drive heading controller: control ticks in, motor voltages out.
// Depends on hdc_pkg and instantiates hdc_volts for each motor side.
//
//   channel  direction  handshake          contents
//   in_      input      in_valid/in_stall  tick or command request
//   out_     output     out_valid/out_stall right/left voltage, active mode
//   cfg_     input      cfg_we             register index and data
//
// One request is accepted per cycle while in_stall is low. A tick passes
// through input register, state/turn stage, scaling multiply,
// correction/sum, and the three voltage converter stages. A command request
// updates the mode state as it leaves the input register and gives no result.
// Reset (synchronous, rst_n low) empties the pipeline and restores state
// and config registers. An output stall backs up stage by stage; bubbles close.
module differential_drive_heading_control (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_opcode,
  input  logic signed [7:0]        in_stick_forward,
  input  logic signed [7:0]        in_stick_turn,
  input  logic                     in_cancel_pressed,
  input  logic [12:0]              in_heading,
  input  logic signed [23:0]       in_encoder_average,
  input  hdc_pkg::mode_t           in_new_mode,
  input  logic signed [13:0]       in_new_face_heading,
  input  logic signed [7:0]        in_new_drive_speed,
  input  logic signed [23:0]       in_new_target_position,
  input  logic                     in_new_slow_turn,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [14:0]       out_right_voltage,
  output logic signed [14:0]       out_left_voltage,
  output hdc_pkg::mode_t           out_active_mode,
  input  logic                     cfg_we,
  input  hdc_pkg::cfg_idx_t        cfg_index,
  input  logic [6:0]               cfg_data
);
  import hdc_pkg::*;

  typedef struct packed {
    logic               opcode;
    logic signed [7:0]  stick_forward;
    logic signed [7:0]  stick_turn;
    logic               cancel_pressed;
    logic [12:0]        heading;
    logic signed [23:0] encoder_average;
    mode_t              new_mode;
    logic signed [13:0] new_face_heading;
    logic signed [7:0]  new_drive_speed;
    logic signed [23:0] new_target_position;
    logic               new_slow_turn;
  } item_t;

  // Squares a stick value's magnitude after the deadzone.
  function automatic logic [14:0] stick_square(logic [7:0] v, logic [6:0] dz);
    logic [7:0] mag;
    logic [7:0] m;
    mag = v[7] ? (~v + 8'd1) : v;
    m   = (mag < {1'b0, dz}) ? 8'd0 : mag;
    return 15'({7'd0, m} * {7'd0, m});
  endfunction

  // Corrects a low-by-one estimate of floor(sq * 256 / 127).
  function automatic logic [15:0] fix_est(logic [15:0] est, logic [14:0] sq);
    logic [22:0] x;
    logic [22:0] m;
    logic [22:0] r;
    x = {sq, 8'd0};
    m = {est, 7'd0} - {7'd0, est};
    r = x - m;
    return (r >= 23'(STICK_DIV)) ? (est + 16'd1) : est;
  endfunction

  // Configuration registers.
  logic [6:0] deadzone_r, max_turn_r, max_slow_turn_r, min_turn_r, min_drive_r;
  logic [5:0] pulse_on_r, pulse_off_r;

  // Controller state.
  mode_t              mode_r;
  logic signed [13:0] face_r;
  logic signed [7:0]  auto_speed_r;
  logic signed [23:0] target_r;
  logic               slow_r;
  logic [6:0]         pulse_cnt_r;

  // Pipeline stages.
  logic               s1_valid_r;
  item_t              s1_item_r;

  logic               s2_valid_r;
  logic [14:0]        s2_fwd_sq_r, s2_turn_sq_r;
  logic               s2_fwd_neg_r, s2_turn_neg_r;
  logic               s2_auto_r, s2_cancel_r;
  logic signed [7:0]  s2_speed_r;
  logic [4:0]         s2_dist_r;
  logic signed [16:0] s2_turn_auto_r;
  mode_t              s2_mode_r;

  logic               s3_valid_r;
  logic [15:0]        s3_fwd_est_r, s3_turn_est_r;
  logic [14:0]        s3_fwd_sq_r, s3_turn_sq_r;
  logic               s3_fwd_neg_r, s3_turn_neg_r;
  logic               s3_auto_r, s3_cancel_r;
  logic signed [16:0] s3_fwd_auto_r, s3_turn_auto_r;
  mode_t              s3_mode_r;

  logic               s4_valid_r;
  logic signed [17:0] s4_sum_right_r, s4_sum_left_r;
  mode_t              s4_mode_r;

  logic               s5_valid_r;
  mode_t              s5_mode_r;
  logic               s6_valid_r;
  mode_t              s6_mode_r;
  logic               out_valid_r;
  mode_t              out_mode_r;

  // Flow control: each stage takes new data when empty or when it drains.
  logic ready_out, ready6, ready5, ready4, ready3, ready2, ready1;
  logic s1_tick, leave1, accept;

  assign ready_out = !out_valid_r || !out_stall;
  assign ready6    = !s6_valid_r || ready_out;
  assign ready5    = !s5_valid_r || ready6;
  assign ready4    = !s4_valid_r || ready5;
  assign ready3    = !s3_valid_r || ready4;
  assign ready2    = !s2_valid_r || ready3;
  assign s1_tick   = (s1_item_r.opcode == OP_TICK);
  assign leave1    = s1_valid_r && (!s1_tick || ready2);
  assign ready1    = !s1_valid_r || leave1;
  assign accept    = in_valid && ready1;
  assign in_stall  = !ready1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r      <= RST_STICK_DEADZONE;
      max_turn_r      <= RST_MAX_TURN;
      max_slow_turn_r <= RST_MAX_SLOW_TURN;
      min_turn_r      <= RST_MIN_TURN;
      min_drive_r     <= RST_MIN_DRIVE;
      pulse_on_r      <= RST_PULSE_ON;
      pulse_off_r     <= RST_PULSE_OFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STICK_DEADZONE: deadzone_r      <= cfg_data;
        REG_MAX_TURN:       max_turn_r      <= cfg_data;
        REG_MAX_SLOW_TURN:  max_slow_turn_r <= cfg_data;
        REG_MIN_TURN:       min_turn_r      <= cfg_data;
        REG_MIN_DRIVE:      min_drive_r     <= cfg_data;
        REG_PULSE_ON:       pulse_on_r      <= cfg_data[5:0];
        REG_PULSE_OFF:      pulse_off_r     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (leave1) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= '{
        opcode:              in_opcode,
        stick_forward:       in_stick_forward,
        stick_turn:          in_stick_turn,
        cancel_pressed:      in_cancel_pressed,
        heading:             in_heading,
        encoder_average:     in_encoder_average,
        new_mode:            in_new_mode,
        new_face_heading:    in_new_face_heading,
        new_drive_speed:     in_new_drive_speed,
        new_target_position: in_new_target_position,
        new_slow_turn:       in_new_slow_turn
      };
    end
  end

  // Stage A: heading error, turn clamp and pulse, distance factor, sticks.
  logic               auto_on, face_none, err_neg, small_turn, boost, pulse_wrap;
  logic signed [15:0] err0, err1, err2, err3, lim_s;
  logic [10:0]        err_mag, turn_mag;
  logic [9:0]         min_turn8;
  logic [6:0]         pulse_inc, pulse_span;
  logic signed [16:0] turn_q8, turn_auto;
  logic signed [24:0] dist_diff;
  logic [24:0]        dist_abs;
  logic [4:0]         dist_sel;
  mode_t              load_mode, mode_after;

  always_comb begin
    auto_on   = (mode_r != MODE_USER);
    face_none = (face_r == FACE_NONE);

    err0 = $signed({3'b000, s1_item_r.heading}) - $signed({{2{face_r[13]}}, face_r});
    err1 = (err0 < 16'sd0) ? (err0 + HEADING_FULL) : err0;
    err2 = (err1 > HEADING_HALF) ? (err1 - HEADING_FULL) : err1;
    lim_s = $signed({6'd0, (slow_r ? max_slow_turn_r : max_turn_r), 3'd0});
    if (err2 > lim_s) begin
      err3 = lim_s;
    end else if (err2 < -lim_s) begin
      err3 = -lim_s;
    end else begin
      err3 = err2;
    end
    err_neg = err3[15];
    err_mag = err_neg ? 11'(-err3) : 11'(err3);

    // Small errors get a minimum power pulse.
    min_turn8  = {min_turn_r, 3'd0};
    small_turn = (err_mag < {1'b0, min_turn8});
    pulse_inc  = pulse_cnt_r + 7'd1;
    pulse_span = {1'b0, pulse_on_r} + {1'b0, pulse_off_r};
    boost      = (pulse_inc > {1'b0, pulse_off_r});
    pulse_wrap = (pulse_inc > pulse_span);
    if (face_none) begin
      turn_mag = 11'd0;
    end else if (small_turn && boost) begin
      turn_mag = {1'b0, min_turn8};
    end else begin
      turn_mag = err_mag;
    end
    turn_q8   = $signed({1'b0, turn_mag, 5'd0});
    turn_auto = err_neg ? -turn_q8 : turn_q8;

    // Remaining distance, saturated; heading mode runs at full speed.
    dist_diff = $signed({target_r[23], target_r}) -
                $signed({s1_item_r.encoder_average[23], s1_item_r.encoder_average});
    dist_abs  = dist_diff[24] ? 25'(-dist_diff) : 25'(dist_diff);
    if (mode_r == MODE_HEADING || dist_abs > 25'(DIST_FULL)) begin
      dist_sel = DIST_FULL;
    end else begin
      dist_sel = dist_abs[4:0];
    end

    load_mode  = (s1_item_r.new_mode == MODE_SPARE) ? MODE_HEADING : s1_item_r.new_mode;
    mode_after = s1_item_r.cancel_pressed ? MODE_USER : mode_r;
  end

  // State updates happen as a request leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_USER;
      face_r       <= FACE_NONE;
      auto_speed_r <= 8'sd0;
      target_r     <= 24'sd0;
      slow_r       <= 1'b0;
      pulse_cnt_r  <= 7'd0;
    end else if (leave1) begin
      if (!s1_tick) begin
        mode_r       <= load_mode;
        face_r       <= s1_item_r.new_face_heading;
        auto_speed_r <= s1_item_r.new_drive_speed;
        target_r     <= s1_item_r.new_target_position;
        slow_r       <= s1_item_r.new_slow_turn;
      end else begin
        if (auto_on && small_turn) begin
          pulse_cnt_r <= pulse_wrap ? 7'd0 : pulse_inc;
        end
        if (s1_item_r.cancel_pressed) begin
          face_r <= FACE_NONE;
          mode_r <= MODE_USER;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      s2_fwd_sq_r    <= stick_square(s1_item_r.stick_forward, deadzone_r);
      s2_fwd_neg_r   <= s1_item_r.stick_forward[7];
      s2_turn_sq_r   <= stick_square(s1_item_r.stick_turn, deadzone_r);
      s2_turn_neg_r  <= s1_item_r.stick_turn[7];
      s2_auto_r      <= auto_on;
      s2_cancel_r    <= s1_item_r.cancel_pressed;
      s2_speed_r     <= auto_speed_r;
      s2_dist_r      <= dist_sel;
      s2_turn_auto_r <= turn_auto;
      s2_mode_r      <= mode_after;
    end
  end

  // Stage B: stick reciprocal estimates, auto speed scaling and minimum.
  logic [30:0]        fwd_prod, turn_prod;
  logic signed [13:0] speed_dist;
  logic signed [16:0] fwd_raw, fwd_min, fwd_auto;

  always_comb begin
    fwd_prod   = 31'(s2_fwd_sq_r) * 31'(STICK_RECIP);
    turn_prod  = 31'(s2_turn_sq_r) * 31'(STICK_RECIP);
    speed_dist = s2_speed_r * $signed({1'b0, s2_dist_r});
    fwd_raw    = $signed({speed_dist[12:0], 4'd0});
    fwd_min    = $signed({2'b00, min_drive_r, 8'd0});
    if (fwd_raw > 17'sd0 && fwd_raw < fwd_min) begin
      fwd_auto = fwd_min;
    end else if (fwd_raw < 17'sd0 && fwd_raw > -fwd_min) begin
      fwd_auto = -fwd_min;
    end else begin
      fwd_auto = fwd_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      s3_fwd_est_r   <= fwd_prod[29:14];
      s3_turn_est_r  <= turn_prod[29:14];
      s3_fwd_sq_r    <= s2_fwd_sq_r;
      s3_turn_sq_r   <= s2_turn_sq_r;
      s3_fwd_neg_r   <= s2_fwd_neg_r;
      s3_turn_neg_r  <= s2_turn_neg_r;
      s3_auto_r      <= s2_auto_r;
      s3_cancel_r    <= s2_cancel_r;
      s3_fwd_auto_r  <= fwd_auto;
      s3_turn_auto_r <= s2_turn_auto_r;
      s3_mode_r      <= s2_mode_r;
    end
  end

  // Stage C: finish the stick squares, pick the source, form both sums.
  logic [15:0]        fwd_q, turn_q;
  logic signed [16:0] fwd_user, turn_user, fwd_sel, turn_sel;

  always_comb begin
    fwd_q     = fix_est(s3_fwd_est_r, s3_fwd_sq_r);
    turn_q    = fix_est(s3_turn_est_r, s3_turn_sq_r);
    fwd_user  = s3_fwd_neg_r ? -$signed({1'b0, fwd_q}) : $signed({1'b0, fwd_q});
    turn_user = s3_turn_neg_r ? -$signed({1'b0, turn_q}) : $signed({1'b0, turn_q});
    if (s3_cancel_r) begin
      fwd_sel  = 17'sd0;
      turn_sel = 17'sd0;
    end else if (s3_auto_r) begin
      fwd_sel  = s3_fwd_auto_r;
      turn_sel = s3_turn_auto_r;
    end else begin
      fwd_sel  = fwd_user;
      turn_sel = turn_user;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4) begin
      s4_sum_right_r <= $signed({fwd_sel[16], fwd_sel}) - $signed({turn_sel[16], turn_sel});
      s4_sum_left_r  <= $signed({fwd_sel[16], fwd_sel}) + $signed({turn_sel[16], turn_sel});
      s4_mode_r      <= s3_mode_r;
    end
  end

  // Voltage conversion stages, one converter per side.
  volt_adv_t volt_adv;

  assign volt_adv = '{abs_load: ready5, est_load: ready6, out_load: ready_out};

  hdc_volts u_volts_right (
    .clk  (clk),
    .adv  (volt_adv),
    .sum  (s4_sum_right_r),
    .volt (out_right_voltage)
  );

  hdc_volts u_volts_left (
    .clk  (clk),
    .adv  (volt_adv),
    .sum  (s4_sum_left_r),
    .volt (out_left_voltage)
  );

  always_ff @(posedge clk) begin
    if (ready5) begin
      s5_mode_r <= s4_mode_r;
    end
    if (ready6) begin
      s6_mode_r <= s5_mode_r;
    end
    if (ready_out) begin
      out_mode_r <= s6_mode_r;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ready2) begin
        s2_valid_r <= leave1 && s1_tick;
      end
      if (ready3) begin
        s3_valid_r <= s2_valid_r;
      end
      if (ready4) begin
        s4_valid_r <= s3_valid_r;
      end
      if (ready5) begin
        s5_valid_r <= s4_valid_r;
      end
      if (ready6) begin
        s6_valid_r <= s5_valid_r;
      end
      if (ready_out) begin
        out_valid_r <= s6_valid_r;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_active_mode = out_mode_r;

endmodule
